>>> rtl/gpqe_pkg.sv
// ----------------------------------------------------------------------------
// gpqe_pkg
// types, font rom and saturating add shared by the glyph quad emitter
// ----------------------------------------------------------------------------
package gpqe_pkg;

  localparam int unsigned CoordWidth = 16;
  localparam int unsigned QueueDepth = 2;
  localparam int unsigned GlyphBits  = 35;
  localparam logic [2:0]  LastCol    = 3'd4;
  localparam logic [3:0]  ScaleReset = 4'd2;

  localparam logic [16:0] CoordMax =
    (CoordWidth >= 16) ? 17'h0FFFF : 17'((64'd1 << CoordWidth) - 64'd1);

  typedef struct packed {
    logic [7:0]  char_code;
    logic        string_start;
    logic [15:0] origin_x;
    logic [15:0] origin_y;
    logic [31:0] rgba_in;
  } in_beat_t;

  typedef struct packed {
    logic [15:0] quad_x0;
    logic [15:0] quad_y0;
    logic [15:0] quad_x1;
    logic [15:0] quad_y1;
    logic [31:0] rgba_out;
    logic        last_quad;
  } out_beat_t;

  typedef struct packed {
    logic [GlyphBits-1:0] glyph;
    logic [15:0]          cur_x;
    logic [15:0]          cur_y;
    logic [31:0]          rgba;
    logic [3:0]           scale;
  } job_t;

  function automatic logic [15:0] sat_add(input logic [15:0] a, input logic [6:0] b);
    logic [16:0] sum;
    sum = {1'b0, a} + 17'(b);
    if (sum > CoordMax) begin
      sum = CoordMax;
    end
    return sum[15:0];
  endfunction

  // rows top to bottom, msb of each row is the leftmost column
  function automatic logic [GlyphBits-1:0] glyph_rom(input logic [7:0] code);
    logic [GlyphBits-1:0] g;
    unique case (code)
      "A": g = {5'h0E, 5'h11, 5'h11, 5'h1F, 5'h11, 5'h11, 5'h11};
      "B": g = {5'h1E, 5'h11, 5'h11, 5'h1E, 5'h11, 5'h11, 5'h1E};
      "C": g = {5'h0E, 5'h11, 5'h10, 5'h10, 5'h10, 5'h11, 5'h0E};
      "D": g = {5'h1C, 5'h12, 5'h11, 5'h11, 5'h11, 5'h12, 5'h1C};
      "E": g = {5'h1F, 5'h10, 5'h10, 5'h1E, 5'h10, 5'h10, 5'h1F};
      "F": g = {5'h1F, 5'h10, 5'h10, 5'h1E, 5'h10, 5'h10, 5'h10};
      "G": g = {5'h0E, 5'h11, 5'h10, 5'h17, 5'h11, 5'h11, 5'h0E};
      "H": g = {5'h11, 5'h11, 5'h11, 5'h1F, 5'h11, 5'h11, 5'h11};
      "I": g = {5'h1F, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04, 5'h1F};
      "J": g = {5'h07, 5'h02, 5'h02, 5'h02, 5'h12, 5'h12, 5'h0C};
      "K": g = {5'h11, 5'h12, 5'h14, 5'h18, 5'h14, 5'h12, 5'h11};
      "L": g = {5'h10, 5'h10, 5'h10, 5'h10, 5'h10, 5'h10, 5'h1F};
      "M": g = {5'h11, 5'h1B, 5'h15, 5'h15, 5'h11, 5'h11, 5'h11};
      "N": g = {5'h11, 5'h11, 5'h19, 5'h15, 5'h13, 5'h11, 5'h11};
      "O": g = {5'h0E, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0E};
      "P": g = {5'h1E, 5'h11, 5'h11, 5'h1E, 5'h10, 5'h10, 5'h10};
      "Q": g = {5'h0E, 5'h11, 5'h11, 5'h11, 5'h15, 5'h12, 5'h0D};
      "R": g = {5'h1E, 5'h11, 5'h11, 5'h1E, 5'h14, 5'h12, 5'h11};
      "S": g = {5'h0F, 5'h10, 5'h10, 5'h0E, 5'h01, 5'h01, 5'h1E};
      "T": g = {5'h1F, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04};
      "U": g = {5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0E};
      "V": g = {5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0A, 5'h04};
      "W": g = {5'h11, 5'h11, 5'h11, 5'h15, 5'h15, 5'h15, 5'h0A};
      "X": g = {5'h11, 5'h11, 5'h0A, 5'h04, 5'h0A, 5'h11, 5'h11};
      "Y": g = {5'h11, 5'h11, 5'h0A, 5'h04, 5'h04, 5'h04, 5'h04};
      "Z": g = {5'h1F, 5'h01, 5'h02, 5'h04, 5'h08, 5'h10, 5'h1F};
      "0": g = {5'h0E, 5'h11, 5'h13, 5'h15, 5'h19, 5'h11, 5'h0E};
      "1": g = {5'h04, 5'h0C, 5'h14, 5'h04, 5'h04, 5'h04, 5'h1F};
      "2": g = {5'h0E, 5'h11, 5'h01, 5'h02, 5'h04, 5'h08, 5'h1F};
      "3": g = {5'h1E, 5'h01, 5'h01, 5'h0E, 5'h01, 5'h01, 5'h1E};
      "4": g = {5'h02, 5'h06, 5'h0A, 5'h12, 5'h1F, 5'h02, 5'h02};
      "5": g = {5'h1F, 5'h10, 5'h10, 5'h1E, 5'h01, 5'h01, 5'h1E};
      "6": g = {5'h0E, 5'h10, 5'h10, 5'h1E, 5'h11, 5'h11, 5'h0E};
      "7": g = {5'h1F, 5'h01, 5'h02, 5'h04, 5'h08, 5'h08, 5'h08};
      "8": g = {5'h0E, 5'h11, 5'h11, 5'h0E, 5'h11, 5'h11, 5'h0E};
      "9": g = {5'h0E, 5'h11, 5'h11, 5'h0F, 5'h01, 5'h01, 5'h0E};
      ":": g = {5'h00, 5'h04, 5'h04, 5'h00, 5'h04, 5'h04, 5'h00};
      ".": g = {5'h00, 5'h00, 5'h00, 5'h00, 5'h00, 5'h0C, 5'h0C};
      "-": g = {5'h00, 5'h00, 5'h00, 5'h1F, 5'h00, 5'h00, 5'h00};
      ">": g = {5'h10, 5'h08, 5'h04, 5'h02, 5'h04, 5'h08, 5'h10};
      "/": g = {5'h01, 5'h02, 5'h04, 5'h08, 5'h10, 5'h00, 5'h00};
      "|": g = {5'h04, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04};
      " ": g = '0;
      // fallback: question mark shape
      default: g = {5'h1F, 5'h11, 5'h02, 5'h04, 5'h08, 5'h00, 5'h08};
    endcase
    return g;
  endfunction

endpackage

>>> rtl/gpqe_queue.sv
// ----------------------------------------------------------------------------
// gpqe_queue
// small fifo of glyph jobs between the front and the back
// ----------------------------------------------------------------------------
module gpqe_queue #(
  parameter int unsigned Depth = gpqe_pkg::QueueDepth
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  gpqe_pkg::job_t  push_data_i,
  output logic            full_o,
  input  logic            pop_i,
  output gpqe_pkg::job_t  pop_data_o,
  output logic            empty_o
);
  import gpqe_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(Depth);

  job_t            mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q;
  logic            do_push, do_pop;

  assign full_o     = (cnt_q == CntFull);
  assign empty_o    = (cnt_q == '0);
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && !empty_o;
  assign pop_data_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

>>> rtl/gpqe_front.sv
// ----------------------------------------------------------------------------
// gpqe_front
// accepts characters, looks up the glyph and keeps the string cursor
// ----------------------------------------------------------------------------
module gpqe_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  gpqe_pkg::in_beat_t  in_beat_i,
  input  logic [3:0]          scale_i,
  output logic                push_o,
  output gpqe_pkg::job_t      job_o,
  input  logic                full_i
);
  import gpqe_pkg::*;

  logic [15:0]          cursor_x_q, cursor_x_d;
  logic [15:0]          cursor_y_q, cursor_y_d;
  logic [15:0]          cur_x, cur_y;
  logic [GlyphBits-1:0] glyph;
  logic [6:0]           advance;
  logic                 accept;

  assign in_stall_o = full_i;
  assign accept     = in_valid_i && !full_i;

  always_comb begin
    cur_x = in_beat_i.string_start ? sat_add(in_beat_i.origin_x, 7'd0) : cursor_x_q;
    cur_y = in_beat_i.string_start ? sat_add(in_beat_i.origin_y, 7'd0) : cursor_y_q;
    glyph = glyph_rom(in_beat_i.char_code);
    // six columns per character cell
    advance = {1'b0, scale_i, 2'b00} + {2'b00, scale_i, 1'b0};
    cursor_x_d = accept ? sat_add(cur_x, advance) : cursor_x_q;
    cursor_y_d = accept ? cur_y : cursor_y_q;
  end

  // blank glyphs only move the cursor
  assign push_o      = accept && (|glyph);
  assign job_o.glyph = glyph;
  assign job_o.cur_x = cur_x;
  assign job_o.cur_y = cur_y;
  assign job_o.rgba  = in_beat_i.rgba_in;
  assign job_o.scale = scale_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cursor_x_q <= '0;
      cursor_y_q <= '0;
    end else begin
      cursor_x_q <= cursor_x_d;
      cursor_y_q <= cursor_y_d;
    end
  end

endmodule

>>> rtl/gpqe_back.sv
// ----------------------------------------------------------------------------
// gpqe_back
// scans one glyph a pixel per cycle unless stalled, emits a quad per lit pixel
// ----------------------------------------------------------------------------
module gpqe_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  output logic                pop_o,
  input  gpqe_pkg::job_t      job_i,
  input  logic                empty_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output gpqe_pkg::out_beat_t out_beat_o
);
  import gpqe_pkg::*;

  logic [GlyphBits-1:0] mask_q, mask_d;
  logic [2:0]           col_q, col_d;
  logic [15:0]          x_q, x_d, y_q, y_d, row_x_q, row_x_d;
  logic [3:0]           s_q, s_d;
  logic [31:0]          rgba_q, rgba_d;
  logic                 out_valid_q, out_valid_d;
  out_beat_t            out_q, out_d;
  logic                 busy, step, load;
  logic [6:0]           s_ext;

  assign busy  = |mask_q;
  assign step  = busy && (!out_valid_q || !out_stall_i);
  assign load  = !busy && !empty_i;
  assign pop_o = load;
  assign s_ext = {3'b000, s_q};

  always_comb begin
    mask_d      = mask_q;
    col_d       = col_q;
    x_d         = x_q;
    y_d         = y_q;
    row_x_d     = row_x_q;
    s_d         = s_q;
    rgba_d      = rgba_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && out_stall_i;
    if (load) begin
      mask_d  = job_i.glyph;
      col_d   = '0;
      x_d     = job_i.cur_x;
      y_d     = job_i.cur_y;
      row_x_d = job_i.cur_x;
      s_d     = job_i.scale;
      rgba_d  = job_i.rgba;
    end else if (step) begin
      if (mask_q[GlyphBits-1]) begin
        out_d.quad_x0   = x_q;
        out_d.quad_y0   = y_q;
        out_d.quad_x1   = sat_add(x_q, s_ext);
        out_d.quad_y1   = sat_add(y_q, s_ext);
        out_d.rgba_out  = rgba_q;
        out_d.last_quad = ~|mask_q[GlyphBits-2:0];
        out_valid_d     = 1'b1;
      end
      mask_d = {mask_q[GlyphBits-2:0], 1'b0};
      if (col_q == LastCol) begin
        col_d = '0;
        x_d   = row_x_q;
        y_d   = sat_add(y_q, s_ext);
      end else begin
        col_d = col_q + 1'b1;
        x_d   = sat_add(x_q, s_ext);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    col_q   <= col_d;
    x_q     <= x_d;
    y_q     <= y_d;
    row_x_q <= row_x_d;
    s_q     <= s_d;
    rgba_q  <= rgba_d;
    out_q   <= out_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      mask_q      <= mask_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_beat_o  = out_q;

endmodule

>>> rtl/glyph_pixel_quad_emitter.sv
// ----------------------------------------------------------------------------
// glyph_pixel_quad_emitter
// 5x7 bitmap font character generator producing one quad per lit pixel
// ----------------------------------------------------------------------------
// in channel: one character per beat (code, string start flag, origin, colour).
// out channel: one quad per lit font pixel, row by row, left to right, with
// last_quad set on the final quad of a character. blank characters give no
// beat but still move the cursor right by six times the pixel scale.
// config: apb register 0 at byte address 0 holds pixel_scale (reset 2).
// the front looks up the glyph in the same cycle it takes the beat and hands it
// to a two-entry job queue; the back loads a job when it is idle, then scans
// the font pixels one per cycle while the output is not stalled and stops after
// the last lit one. a quad leaves the cycle after its pixel is scanned: when
// the top left pixel is lit, the first quad follows the character through the
// job queue, the load into the back and the output register. the input stalls
// only while the job queue is full. a stall on the output holds the pending
// quad and freezes the scan at the current pixel.
// reset clears the cursor to 0,0, empties the queue and drops any quad in
// flight. coordinates saturate at 65535.
// ----------------------------------------------------------------------------
module glyph_pixel_quad_emitter #(
  parameter int unsigned QUEUE_DEPTH = gpqe_pkg::QueueDepth
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  gpqe_pkg::in_beat_t  in_beat_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output gpqe_pkg::out_beat_t out_beat_o,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);
  import gpqe_pkg::*;

  logic [3:0] scale_q;
  logic       scale_hit;
  logic       push, full, pop, empty;
  job_t       push_job, pop_job;

  assign pready    = 1'b1;
  assign scale_hit = (paddr[2] == 1'b0);
  assign prdata    = scale_hit ? {28'd0, scale_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scale_q <= ScaleReset;
    end else if (psel && penable && pwrite && pready && scale_hit) begin
      scale_q <= pwdata[3:0];
    end
  end

  gpqe_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_beat_i  (in_beat_i),
    .scale_i    (scale_q),
    .push_o     (push),
    .job_o      (push_job),
    .full_i     (full)
  );

  gpqe_queue #(
    .Depth (QUEUE_DEPTH)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_job),
    .full_o      (full),
    .pop_i       (pop),
    .pop_data_o  (pop_job),
    .empty_o     (empty)
  );

  gpqe_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_o       (pop),
    .job_i       (pop_job),
    .empty_i     (empty),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_beat_o  (out_beat_o)
  );

endmodule
